/* hdl/ypvm_pkg.sv */
// Shared constants, types and widths of the yaw/pitch view matrix block.
package ypvm_pkg;

	localparam int ANGLE_BITS   = 16;
	localparam int CORDIC_STEPS = 24;
	localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
	localparam int X_W          = 34;
	localparam int Z_W          = 33;
	localparam int TRIG_W       = 18;
	localparam int F_W          = 18;
	localparam int SQ_W         = 36;
	localparam int SQ_STEPS     = SQ_W / 2;
	localparam int ROOT_W       = SQ_STEPS;
	localparam int Q_W          = 18;
	localparam int NUM_W        = 35;
	localparam int S_W          = Q_W + 1;
	localparam int DIV_LAT      = Q_W + 2;
	localparam int U_W          = 19;
	localparam int P_W          = 51;
	localparam int DOT_W        = 56;
	localparam int ENT_W        = 32;

	localparam logic signed [X_W-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [ENT_W-1:0] ONE_Q16 = 32'sd65536;

	localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10680862, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81
	};

	typedef struct packed {
		logic signed [ENT_W-1:0] x;
		logic signed [ENT_W-1:0] y;
		logic signed [ENT_W-1:0] z;
	} eye_t;

	typedef struct packed {
		logic signed [F_W-1:0] f0;
		logic signed [F_W-1:0] f1;
		logic signed [F_W-1:0] f2;
		eye_t                  e;
		logic                  zl;
	} carry_t;

	typedef struct packed {
		logic signed [ENT_W-1:0] e0;
		logic signed [ENT_W-1:0] e1;
		logic signed [ENT_W-1:0] e2;
		logic signed [ENT_W-1:0] e3;
	} row_t;

endpackage

/* hdl/ypvm_cordic.sv */
// Pipelined CORDIC giving cosine and sine in signed Q2.16 of a binary angle.
module ypvm_cordic (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic [ypvm_pkg::ANGLE_BITS-1:0]        angle,
	output logic                                   out_valid,
	output logic signed [ypvm_pkg::TRIG_W-1:0]     cos_val,
	output logic signed [ypvm_pkg::TRIG_W-1:0]     sin_val
);
	localparam int N = ypvm_pkg::CORDIC_STEPS;
	localparam int XW = ypvm_pkg::X_W;
	localparam int ZW = ypvm_pkg::Z_W;
	localparam int TW = ypvm_pkg::TRIG_W;
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	logic signed [XW-1:0] x_s [N+1];
	logic signed [XW-1:0] y_s [N+1];
	logic signed [ZW-1:0] z_s [N+1];
	logic [1:0]           quad_s [N+1];
	logic                 v_s [N+1];
	logic [31:0]          phase;
	logic signed [XW-1:0] cr, sr;
	logic signed [TW-1:0] c, s;

	assign phase = 32'(angle) << (32 - ypvm_pkg::ANGLE_BITS);

	always_ff @(posedge clk) begin
		x_s[0]    <= ypvm_pkg::CORDIC_GAIN;
		y_s[0]    <= '0;
		z_s[0]    <= $signed({{(ZW-30){1'b0}}, phase[29:0]});
		quad_s[0] <= phase[31:30];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= N; i++) v_s[i] <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
			for (int i = 0; i < N; i++) v_s[i+1] <= v_s[i];
			out_valid <= v_s[N];
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk) begin
			quad_s[i+1] <= quad_s[i];
			if (!z_s[i][ZW-1]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - $signed({1'b0, ypvm_pkg::ATAN_TURN[i]});
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + $signed({1'b0, ypvm_pkg::ATAN_TURN[i]});
			end
		end
	end

	assign cr = (x_s[N] + XW'(8192)) >>> 14;
	assign sr = (y_s[N] + XW'(8192)) >>> 14;
	assign c  = cr[TW-1:0];
	assign s  = sr[TW-1:0];

	always_ff @(posedge clk) begin
		case (quad_s[N])
			QUAD_0: begin
				cos_val <= c;
				sin_val <= s;
			end
			QUAD_1: begin
				cos_val <= -s;
				sin_val <= c;
			end
			QUAD_2: begin
				cos_val <= -c;
				sin_val <= -s;
			end
			QUAD_3: begin
				cos_val <= s;
				sin_val <= -c;
			end
			default: begin
				cos_val <= c;
				sin_val <= s;
			end
		endcase
	end

endmodule

/* hdl/ypvm_div.sv */
// Pipelined restoring divider that normalizes two components by a length.
module ypvm_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic signed [ypvm_pkg::F_W-1:0]     a,
	input  logic signed [ypvm_pkg::F_W-1:0]     b,
	input  logic [ypvm_pkg::ROOT_W-1:0]         len,
	output logic                                out_valid,
	output logic signed [ypvm_pkg::S_W-1:0]     qa,
	output logic signed [ypvm_pkg::S_W-1:0]     qb
);
	localparam int QW = ypvm_pkg::Q_W;
	localparam int RW = ypvm_pkg::ROOT_W;
	localparam int NW = ypvm_pkg::NUM_W;
	localparam int FW = ypvm_pkg::F_W;
	localparam int SW = ypvm_pkg::S_W;

	logic              v_s [QW+1];
	logic [RW-1:0]     len_s [QW+1];
	logic signed [SW-1:0] res [2];

	assign qa = res[0];
	assign qb = res[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= QW; i++) v_s[i] <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
			for (int i = 0; i < QW; i++) v_s[i+1] <= v_s[i];
			out_valid <= v_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		len_s[0] <= len;
		for (int i = 0; i < QW; i++) len_s[i+1] <= len_s[i];
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic signed [FW-1:0] src;
		logic [FW-1:0]        mag;
		logic [NW-1:0]        num;
		logic [RW-1:0]        r_s [QW+1];
		logic [QW-1:0]        nl_s [QW+1];
		logic [QW-1:0]        q_s [QW+1];
		logic                 neg_s [QW+1];

		assign src = (l == 0) ? a : b;
		assign mag = src[FW-1] ? FW'(-src) : FW'(src);
		assign num = (NW'(mag) << 16) + NW'(len >> 1);

		always_ff @(posedge clk) begin
			r_s[0]   <= RW'(num >> QW);
			nl_s[0]  <= num[QW-1:0];
			q_s[0]   <= '0;
			neg_s[0] <= src[FW-1];
		end

		for (genvar i = 0; i < QW; i++) begin : g_bit
			logic [RW:0] rn;
			assign rn = {r_s[i], nl_s[i][QW-1]};
			always_ff @(posedge clk) begin
				nl_s[i+1]  <= nl_s[i] << 1;
				neg_s[i+1] <= neg_s[i];
				if (rn >= {1'b0, len_s[i]}) begin
					r_s[i+1] <= RW'(rn - {1'b0, len_s[i]});
					q_s[i+1] <= {q_s[i][QW-2:0], 1'b1};
				end else begin
					r_s[i+1] <= rn[RW-1:0];
					q_s[i+1] <= {q_s[i][QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			res[l] <= neg_s[QW] ? -$signed({1'b0, q_s[QW]}) : $signed({1'b0, q_s[QW]});
		end
	end

endmodule

/* hdl/yaw_pitch_view_matrix_top.sv */
// Top level of the yaw/pitch view matrix pipeline with its row output sequencer.
// An item is taken when start is high and busy is low; busy then stays high, so a new item
// waits until busy falls again, a spacing set by the output port that moves one matrix row
// per cycle. The four rows of an item appear on consecutive cycles, row 0 first, marked by
// strobe. The receiver cannot stall: each row is on the ports for one cycle only.
// The path is a 24-stage CORDIC per angle, an 18-stage square root, an 18-stage divider
// and five stages of products and sums.
module yaw_pitch_view_matrix_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [ypvm_pkg::ANGLE_BITS-1:0]        yaw_angle,
	input  logic [ypvm_pkg::ANGLE_BITS-1:0]        pitch_angle,
	input  logic signed [31:0]                     eye_x,
	input  logic signed [31:0]                     eye_y,
	input  logic signed [31:0]                     eye_z,
	output logic                                   strobe,
	output logic [1:0]                             row_index,
	output logic signed [31:0]                     entry_0,
	output logic signed [31:0]                     entry_1,
	output logic signed [31:0]                     entry_2,
	output logic signed [31:0]                     entry_3,
	output logic                                   last_row
);
	localparam int CL = ypvm_pkg::CORDIC_LAT;
	localparam int SN = ypvm_pkg::SQ_STEPS;
	localparam int DL = ypvm_pkg::DIV_LAT;
	localparam int TW = ypvm_pkg::TRIG_W;
	localparam int FW = ypvm_pkg::F_W;
	localparam int SW = ypvm_pkg::S_W;
	localparam int UW = ypvm_pkg::U_W;
	localparam int PW = ypvm_pkg::P_W;
	localparam int DW = ypvm_pkg::DOT_W;
	localparam int RW = ypvm_pkg::ROOT_W;
	localparam int QW = ypvm_pkg::SQ_W;
	localparam int EW = ypvm_pkg::ENT_W;
	localparam logic [1:0] LAST_ROW = 2'd3;

	function automatic logic signed [EW-1:0] rnd_sat(input logic signed [DW-1:0] v);
		logic signed [DW-1:0] t;
		t = (v + DW'(32768)) >>> 16;
		if (t > DW'(64'sh7FFFFFFF)) rnd_sat = 32'sh7FFFFFFF;
		else if (t < -DW'(64'sh80000000)) rnd_sat = 32'sh80000000;
		else rnd_sat = t[EW-1:0];
	endfunction

	logic [1:0] busy_q;
	logic       accept;

	assign accept = start && !busy;
	assign busy   = busy_q != 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 2'd0;
		end else if (accept) begin
			busy_q <= 2'd3;
		end else if (busy_q != 2'd0) begin
			busy_q <= busy_q - 2'd1;
		end
	end

	// Angles go through the CORDIC units while the eye rides a delay line beside them.
	logic                 cy_v, cp_v;
	logic signed [TW-1:0] cy, sy, cp, sp;
	ypvm_pkg::eye_t       e_dly [CL];

	ypvm_cordic u_yaw (
		.clk(clk), .arst_n(arst_n), .in_valid(accept), .angle(yaw_angle),
		.out_valid(cy_v), .cos_val(cy), .sin_val(sy)
	);

	ypvm_cordic u_pitch (
		.clk(clk), .arst_n(arst_n), .in_valid(accept), .angle(pitch_angle),
		.out_valid(cp_v), .cos_val(cp), .sin_val(sp)
	);

	always_ff @(posedge clk) begin
		e_dly[0] <= '{x: eye_x, y: eye_y, z: eye_z};
		for (int i = 1; i < CL; i++) e_dly[i] <= e_dly[i-1];
	end

	// Forward vector.
	logic signed [2*TW-1:0] pf0, pf2;
	ypvm_pkg::carry_t       c_s1;
	logic                   v_s1;

	assign pf0 = cp * cy;
	assign pf2 = cp * sy;

	always_ff @(posedge clk) begin
		c_s1.f0 <= FW'((pf0 + (2*TW)'(32768)) >>> 16);
		c_s1.f1 <= FW'(sp);
		c_s1.f2 <= FW'((pf2 + (2*TW)'(32768)) >>> 16);
		c_s1.e  <= e_dly[CL-1];
		c_s1.zl <= 1'b0;
	end

	// Square root of the horizontal length, two bits of radicand per stage.
	logic signed [2*FW-1:0] sq0, sq2;
	logic [RW:0]            sq_rem_s [SN+1];
	logic [RW-1:0]          sq_root_s [SN+1];
	logic [QW-1:0]          sq_val_s [SN+1];
	ypvm_pkg::carry_t       sq_c_s [SN+1];
	logic                   sq_v_s [SN+1];

	assign sq0 = c_s1.f0 * c_s1.f0;
	assign sq2 = c_s1.f2 * c_s1.f2;

	always_ff @(posedge clk) begin
		sq_rem_s[0]  <= '0;
		sq_root_s[0] <= '0;
		sq_val_s[0]  <= QW'($unsigned(sq0)) + QW'($unsigned(sq2));
		sq_c_s[0]    <= c_s1;
	end

	for (genvar i = 0; i < SN; i++) begin : g_sqrt
		logic [RW+2:0] remn, trial;
		assign remn  = {sq_rem_s[i], sq_val_s[i][QW-1 -: 2]};
		assign trial = {1'b0, sq_root_s[i], 2'b01};
		always_ff @(posedge clk) begin
			sq_val_s[i+1] <= sq_val_s[i] << 2;
			sq_c_s[i+1]   <= sq_c_s[i];
			if (remn >= trial) begin
				sq_rem_s[i+1]  <= (RW+1)'(remn - trial);
				sq_root_s[i+1] <= {sq_root_s[i][RW-2:0], 1'b1};
			end else begin
				sq_rem_s[i+1]  <= remn[RW:0];
				sq_root_s[i+1] <= {sq_root_s[i][RW-2:0], 1'b0};
			end
		end
	end

	// Normalization of the right vector.
	ypvm_pkg::carry_t     dv_c_s [DL];
	logic                 dv_v;
	logic signed [SW-1:0] qa, qb;

	ypvm_div u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(sq_v_s[SN]),
		.a(sq_c_s[SN].f2), .b(sq_c_s[SN].f0), .len(sq_root_s[SN]),
		.out_valid(dv_v), .qa(qa), .qb(qb)
	);

	always_ff @(posedge clk) begin
		dv_c_s[0] <= '{f0: sq_c_s[SN].f0, f1: sq_c_s[SN].f1, f2: sq_c_s[SN].f2,
			e: sq_c_s[SN].e, zl: sq_root_s[SN] == '0};
		for (int i = 1; i < DL; i++) dv_c_s[i] <= dv_c_s[i-1];
	end

	// Right vector, then up vector and the eye dot products.
	ypvm_pkg::carry_t     c_s3, c_s4, c_s5, c_s6, c_s7;
	logic signed [SW-1:0] s0_s3, s2_s3, s0_s4, s2_s4, s0_s5, s2_s5;
	logic signed [SW-1:0] s0_s6, s2_s6, s0_s7, s2_s7;
	logic signed [SW+FW-1:0] ma_s4, mb_s4, mc_s4, md_s4;
	logic signed [PW-1:0] ps0_s4, ps2_s4, pf0_s4, pf1_s4, pf2_s4;
	logic signed [UW-1:0] u0_s5, u1_s5, u2_s5, u0_s6, u1_s6, u2_s6, u0_s7, u1_s7, u2_s7;
	logic signed [EW-1:0] r30_s5, r32_s5, r30_s6, r32_s6, r30_s7, r31_s7, r32_s7;
	logic signed [PW-1:0] pu0_s6, pu1_s6, pu2_s6;
	logic signed [39:0]   t0, t1, t2;

	always_ff @(posedge clk) begin
		c_s3  <= dv_c_s[DL-1];
		s0_s3 <= dv_c_s[DL-1].zl ? SW'(0) : -qa;
		s2_s3 <= dv_c_s[DL-1].zl ? SW'(0) : qb;
	end

	always_ff @(posedge clk) begin
		c_s4   <= c_s3;
		s0_s4  <= s0_s3;
		s2_s4  <= s2_s3;
		ma_s4  <= s2_s3 * c_s3.f1;
		mb_s4  <= s2_s3 * c_s3.f0;
		mc_s4  <= s0_s3 * c_s3.f2;
		md_s4  <= s0_s3 * c_s3.f1;
		ps0_s4 <= PW'(s0_s3) * PW'(c_s3.e.x);
		ps2_s4 <= PW'(s2_s3) * PW'(c_s3.e.z);
		pf0_s4 <= PW'(c_s3.f0) * PW'(c_s3.e.x);
		pf1_s4 <= PW'(c_s3.f1) * PW'(c_s3.e.y);
		pf2_s4 <= PW'(c_s3.f2) * PW'(c_s3.e.z);
	end

	assign t0 = (-(40'(ma_s4)) + 40'sd32768) >>> 16;
	assign t1 = (40'(mb_s4) - 40'(mc_s4) + 40'sd32768) >>> 16;
	assign t2 = (40'(md_s4) + 40'sd32768) >>> 16;

	always_ff @(posedge clk) begin
		c_s5   <= c_s4;
		s0_s5  <= s0_s4;
		s2_s5  <= s2_s4;
		u0_s5  <= t0[UW-1:0];
		u1_s5  <= t1[UW-1:0];
		u2_s5  <= t2[UW-1:0];
		r30_s5 <= rnd_sat(-(DW'(ps0_s4) + DW'(ps2_s4)));
		r32_s5 <= rnd_sat(DW'(pf0_s4) + DW'(pf1_s4) + DW'(pf2_s4));
	end

	always_ff @(posedge clk) begin
		c_s6   <= c_s5;
		s0_s6  <= s0_s5;
		s2_s6  <= s2_s5;
		u0_s6  <= u0_s5;
		u1_s6  <= u1_s5;
		u2_s6  <= u2_s5;
		r30_s6 <= r30_s5;
		r32_s6 <= r32_s5;
		pu0_s6 <= PW'(u0_s5) * PW'(c_s5.e.x);
		pu1_s6 <= PW'(u1_s5) * PW'(c_s5.e.y);
		pu2_s6 <= PW'(u2_s5) * PW'(c_s5.e.z);
	end

	always_ff @(posedge clk) begin
		c_s7   <= c_s6;
		s0_s7  <= s0_s6;
		s2_s7  <= s2_s6;
		u0_s7  <= u0_s6;
		u1_s7  <= u1_s6;
		u2_s7  <= u2_s6;
		r30_s7 <= r30_s6;
		r32_s7 <= r32_s6;
		r31_s7 <= rnd_sat(-(DW'(pu0_s6) + DW'(pu1_s6) + DW'(pu2_s6)));
	end

	logic v_s3, v_s4, v_s5, v_s6, v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int i = 0; i <= SN; i++) sq_v_s[i] <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= cy_v && cp_v;
			sq_v_s[0] <= v_s1;
			for (int i = 0; i < SN; i++) sq_v_s[i+1] <= sq_v_s[i];
			v_s3 <= dv_v;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Row sequencer: the finished matrix is held and shown one row per cycle.
	ypvm_pkg::row_t mat_q [4];
	logic [1:0]     row_q;
	logic           active_q;

	always_ff @(posedge clk) begin
		if (v_s7) begin
			mat_q[0] <= '{e0: EW'(s0_s7), e1: EW'(u0_s7), e2: -(EW'(c_s7.f0)), e3: '0};
			mat_q[1] <= '{e0: '0, e1: EW'(u1_s7), e2: -(EW'(c_s7.f1)), e3: '0};
			mat_q[2] <= '{e0: EW'(s2_s7), e1: EW'(u2_s7), e2: -(EW'(c_s7.f2)), e3: '0};
			mat_q[3] <= '{e0: r30_s7, e1: r31_s7, e2: r32_s7, e3: ypvm_pkg::ONE_Q16};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= 2'd0;
			active_q <= 1'b0;
		end else if (v_s7) begin
			row_q    <= 2'd0;
			active_q <= 1'b1;
		end else if (active_q) begin
			row_q    <= row_q + 2'd1;
			active_q <= row_q != LAST_ROW;
		end
	end

	assign strobe    = active_q;
	assign row_index = row_q;
	assign entry_0   = mat_q[row_q].e0;
	assign entry_1   = mat_q[row_q].e1;
	assign entry_2   = mat_q[row_q].e2;
	assign entry_3   = mat_q[row_q].e3;
	assign last_row  = row_q == LAST_ROW;

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after an accepted item");

	a_rows_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && row_index != LAST_ROW |=> strobe && row_index == $past(row_index) + 2'd1)
		else $error("matrix rows not emitted back to back");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 |-> !active_q || row_q == LAST_ROW)
		else $error("new matrix arrived while rows were still pending");

	a_cordic_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		cy_v == cp_v)
		else $error("angle units out of step");
`endif

endmodule
